@@ src/weighted_index_sampler_defines.svh @@
// ---------------------------------------------------------------------------
// Weighted index sampler: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_INDEX_SAMPLER_DEFINES_SVH
`define WEIGHTED_INDEX_SAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WIS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wis_pkg.sv @@
// ---------------------------------------------------------------------------
// Weighted index sampler package
// Fixed field widths and constants of the sampler and its channels.
// ---------------------------------------------------------------------------
package wis_pkg;

  localparam int IN_WEIGHT_W = 16;   // width of the weight field on the port
  localparam int DRAW_W      = 17;   // uniform draw, 65536 stands for 1.0
  localparam int FRAC_BITS   = 16;   // fraction bits of the draw
  localparam int INDEX_W     = 6;    // width of the reported index

  localparam logic [DRAW_W-1:0] DRAW_ONE = DRAW_W'(65536);

  typedef logic [IN_WEIGHT_W-1:0] weight_t;
  typedef logic [DRAW_W-1:0]      draw_t;
  typedef logic [INDEX_W-1:0]     index_t;

endpackage

@@ src/wis_if.sv @@
// ---------------------------------------------------------------------------
// Weighted index sampler channels
// Valid/ready channels for weight beats and for draw results.
// ---------------------------------------------------------------------------
interface wis_in_if;
  logic              valid;
  logic              ready;
  wis_pkg::weight_t  weight;
  logic              last_weight;
  wis_pkg::draw_t    draw_value;

  modport source (output valid, output weight, output last_weight, output draw_value,
                  input ready);
  modport sink   (input valid, input weight, input last_weight, input draw_value,
                  output ready);
endinterface

interface wis_out_if;
  logic             valid;
  logic             ready;
  wis_pkg::index_t  chosen_index;
  logic             no_choice;

  modport source (output valid, output chosen_index, output no_choice, input ready);
  modport sink   (input valid, input chosen_index, input no_choice, output ready);
endinterface

@@ src/weighted_index_sampler.sv @@
// ---------------------------------------------------------------------------
// Weighted index sampler
// Roulette wheel selection over a set of stored weights.
// ---------------------------------------------------------------------------
// Each input beat stores one weight and adds it to the running total; beats
// beyond MAX_WEIGHTS are dropped. The beat marked last_weight also carries a
// uniform draw u (65536 = 1.0, larger values clip to 1.0) and starts a draw:
// the block reports the first index whose prefix sum P satisfies
// u * total <= P * 65536, or no_choice when the total is zero. The set is then
// cleared. An unmarked beat does not hold off the next one. A marked beat
// holds off the next beat while the block forms u * total, then walks the
// weights, reading the weight memory one entry a cycle (stopping early when
// an index qualifies, skipping the walk when the total is zero), and then
// moves the result into the output register, waiting while the previous
// result there has not been taken. A finished result waits in that output
// register, so the next set can load while it is not yet taken.
module weighted_index_sampler #(
  parameter int MAX_WEIGHTS = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  wis_in_if.sink             in_ch,
  wis_out_if.source          out_ch
);

`include "weighted_index_sampler_defines.svh"

  localparam int SW  = (WEIGHT_BITS < wis_pkg::IN_WEIGHT_W) ? WEIGHT_BITS
                                                            : wis_pkg::IN_WEIGHT_W;
  localparam int AW  = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
  localparam int CW  = $clog2(MAX_WEIGHTS + 1);
  localparam int TW  = SW + CW;
  localparam int PW  = wis_pkg::DRAW_W + TW;
  localparam int IXW = (AW > wis_pkg::INDEX_W) ? AW : wis_pkg::INDEX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [SW-1:0]              mem [MAX_WEIGHTS];
  logic [SW-1:0]              rdata_r;
  logic [AW-1:0]              rd_addr;

  logic [1:0]                 state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [TW-1:0]              total_r, total_nxt;
  logic [wis_pkg::DRAW_W-1:0] u_r, u_nxt;
  logic [PW-1:0]              target_r, target_nxt;
  logic [TW-1:0]              prefix_r, prefix_nxt;
  logic [AW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]              res_idx_r, res_idx_nxt;
  logic                       res_fail_r, res_fail_nxt;

  logic                       out_valid_r, out_valid_nxt;
  wis_pkg::index_t            out_idx_r, out_idx_nxt;
  logic                       out_fail_r, out_fail_nxt;

  logic                       in_beat;
  logic                       wr_en;
  logic [SW-1:0]              w_in;
  logic [TW-1:0]              prefix_sum;
  logic [PW-1:0]              scaled;
  logic                       hit;
  logic                       at_end;
  logic [IXW-1:0]             idx_ext;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_beat             = in_ch.valid && in_ch.ready;
  assign w_in                = in_ch.weight[SW-1:0];
  assign wr_en               = in_beat && (count_r < CW'(MAX_WEIGHTS));

  assign out_ch.valid        = out_valid_r;
  assign out_ch.chosen_index = out_idx_r;
  assign out_ch.no_choice    = out_fail_r;

  // Prefix test of the entry whose data arrives this cycle.
  assign prefix_sum = prefix_r + TW'(rdata_r);
  assign scaled     = PW'({prefix_sum, {wis_pkg::FRAC_BITS{1'b0}}});
  assign hit        = (target_r <= scaled);
  assign at_end     = ({1'b0, rd_idx_r} == (count_r - CW'(1)));
  assign idx_ext    = IXW'(res_idx_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    u_nxt         = u_r;
    target_nxt    = target_r;
    prefix_nxt    = prefix_r;
    rd_idx_nxt    = rd_idx_r;
    rd_addr       = rd_idx_r + AW'(1);
    res_idx_nxt   = res_idx_r;
    res_fail_nxt  = res_fail_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_fail_nxt  = out_fail_r;

    unique case (state_r)
      ST_IDLE: begin
        if (wr_en) begin
          count_nxt = count_r + CW'(1);
          total_nxt = total_r + TW'(w_in);
        end
        if (in_beat && in_ch.last_weight) begin
          u_nxt     = (in_ch.draw_value > wis_pkg::DRAW_ONE) ? wis_pkg::DRAW_ONE
                                                             : in_ch.draw_value;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        target_nxt = PW'(u_r) * PW'(total_r);
        prefix_nxt = '0;
        rd_addr    = '0;
        rd_idx_nxt = '0;
        if (total_r == '0) begin
          res_idx_nxt  = '0;
          res_fail_nxt = 1'b1;
          count_nxt    = '0;
          state_nxt    = ST_DONE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        prefix_nxt = prefix_sum;
        rd_idx_nxt = rd_idx_r + AW'(1);
        if (hit || at_end) begin
          res_idx_nxt  = hit ? rd_idx_r : '0;
          res_fail_nxt = !hit;
          count_nxt    = '0;
          total_nxt    = '0;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_ext[wis_pkg::INDEX_W-1:0];
          out_fail_nxt  = res_fail_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Weight memory: one write port for loading, one registered read for the walk.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= w_in;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    target_r   <= target_nxt;
    prefix_r   <= prefix_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_fail_r <= res_fail_nxt;
    out_idx_r  <= out_idx_nxt;
    out_fail_r <= out_fail_nxt;
  end

  `WIS_ASSERT_SAME(a_walk_in_range, state_r == ST_WALK,
                   {1'b0, rd_idx_r} < count_r, "walk index beyond stored weights")
  `WIS_ASSERT_SAME(a_total_implies_count, total_r != '0,
                   count_r != '0, "nonzero total with an empty store")
  `WIS_ASSERT_NEXT(a_last_starts_draw, in_beat && in_ch.last_weight,
                   state_r == ST_MUL, "marked beat did not start a draw")

endmodule

@@ tb/tb_weighted_index_sampler.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Weighted index sampler testbench
// Drives weight beats and draws through the valid/ready channels, predicts
// each draw result from its copy of the weight wheel or the directed table,
// checks every result beat in order. Directed table first, then random sets.
// ---------------------------------------------------------------------------
module tb_weighted_index_sampler;

  localparam int              WHEEL_DEPTH = 64;
  localparam longint unsigned DRAW_SCALE  = 64'd1 << wis_pkg::FRAC_BITS;
  localparam int              RANDOM_BEATS = 1000;
  localparam int              DRAIN_CYCLES = 80;

  typedef struct packed {
    wis_pkg::index_t idx;
    logic            nc;
  } draw_result_t;

  typedef struct {
    wis_pkg::weight_t w;
    logic             last;
    wis_pkg::draw_t   d;
    bit               typed;
    draw_result_t     res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  wis_in_if  in_ch ();
  wis_out_if out_ch ();

  weighted_index_sampler DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: the weights of the current set and their total.
  wis_pkg::weight_t wheel_w [WHEEL_DEPTH];
  int unsigned      wheel_count;
  longint unsigned  wheel_total;

  draw_result_t pending_draws [$];
  stim_row_t    dir_rows [$];

  int unsigned errors;
  int unsigned beats_sent;
  int unsigned draws_checked;
  int unsigned no_choice_seen;
  int unsigned overflow_sets;
  int unsigned longest_set;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("%0t: timeout with %0d draw results outstanding", $time, pending_draws.size());
    $display("tb_weighted_index_sampler: FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic wis_pkg::weight_t pick_weight(input int unsigned style);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (style)
      0: begin
        return wis_pkg::weight_t'($urandom_range(0, 65535));
      end
      1: begin
        return wis_pkg::weight_t'($urandom_range(0, 15));
      end
      2: begin
        if (r < 30) return '0;
        if (r < 50) return '1;
        return wis_pkg::weight_t'($urandom_range(0, 65535));
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  function automatic wis_pkg::draw_t pick_draw();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return wis_pkg::DRAW_ONE;
    if (r < 30) return wis_pkg::draw_t'($urandom_range(65537, 131071));
    return wis_pkg::draw_t'($urandom_range(0, 65536));
  endfunction

  // Updates the predicted wheel with one accepted beat; on a marked beat it
  // walks the prefix sums and clears the set.
  task automatic wheel_take(input wis_pkg::weight_t w, input logic l,
                            input wis_pkg::draw_t d,
                            output bit fired, output draw_result_t res);
    longint unsigned u;
    longint unsigned target;
    longint unsigned prefix;
    bit              found;
    fired = 1'b0;
    res   = '{idx: '0, nc: 1'b1};
    if (wheel_count < WHEEL_DEPTH) begin
      wheel_w[wheel_count] = w;
      wheel_count++;
      wheel_total += w;
    end
    if (l) begin
      fired  = 1'b1;
      u      = (d > wis_pkg::DRAW_ONE) ? longint'(wis_pkg::DRAW_ONE) : longint'(d);
      target = u * wheel_total;
      prefix = 0;
      found  = 1'b0;
      if (wheel_total != 0) begin
        for (int i = 0; i < wheel_count && !found; i++) begin
          prefix += wheel_w[i];
          if (target <= prefix * DRAW_SCALE) begin
            res.idx = wis_pkg::index_t'(i);
            res.nc  = 1'b0;
            found   = 1'b1;
          end
        end
      end
      wheel_count = 0;
      wheel_total = 0;
    end
  endtask

  // Presents one beat and holds it until accepted. valid is left high so the
  // caller decides whether a gap follows.
  task automatic send_beat(input wis_pkg::weight_t w, input logic l,
                           input wis_pkg::draw_t d,
                           input bit typed, input draw_result_t typed_res);
    bit           fired;
    draw_result_t res;
    in_ch.valid       <= 1'b1;
    in_ch.weight      <= w;
    in_ch.last_weight <= l;
    in_ch.draw_value  <= d;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    beats_sent++;
    wheel_take(w, l, d, fired, res);
    if (fired) begin
      pending_draws.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic idle_after_beat(input int unsigned gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_drawn();
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input wis_pkg::weight_t w, input logic l,
                         input wis_pkg::draw_t d,
                         input bit typed, input wis_pkg::index_t idx, input logic nc);
    stim_row_t row;
    row.w     = w;
    row.last  = l;
    row.d     = d;
    row.typed = typed;
    row.res   = '{idx: idx, nc: nc};
    dir_rows.push_back(row);
  endtask

  // Result side: random back-pressure, with occasional long steady stretches.
  initial begin
    int unsigned burst;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Result checker: each result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    draw_result_t got;
    draw_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{idx: out_ch.chosen_index, nc: out_ch.no_choice};
      if (pending_draws.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, index %0d no_choice %0b",
                 $time, got.idx, got.nc);
      end else begin
        want = pending_draws.pop_front();
        draws_checked++;
        if (got.nc === 1'b1) no_choice_seen++;
        if (got.idx !== want.idx) begin
          errors++;
          $display("%0t: chosen_index mismatch, expected %0d, actual %0d",
                   $time, want.idx, got.idx);
        end
        if (got.nc !== want.nc) begin
          errors++;
          $display("%0t: no_choice mismatch, expected %0b, actual %0b",
                   $time, want.nc, got.nc);
        end
      end
    end
  end

  initial begin
    int unsigned      len;
    int unsigned      style;
    int unsigned      gap;
    bit               steady;
    bit               pause;
    bit               zero_set;
    wis_pkg::weight_t w;
    wis_pkg::draw_t   d;
    draw_result_t     none;

    none           = '{idx: '0, nc: 1'b0};
    errors         = 0;
    beats_sent     = 0;
    draws_checked  = 0;
    no_choice_seen = 0;
    overflow_sets  = 0;
    longest_set    = 0;
    wheel_count    = 0;
    wheel_total    = 0;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.weight      <= '0;
    in_ch.last_weight <= 1'b0;
    in_ch.draw_value  <= '0;

    // Zero-total wheel right after reset, then single weights at the extremes.
    add_row(16'd0,     1'b1, 17'd0,      1'b1, 6'd0, 1'b1);
    add_row(16'd0,     1'b1, wis_pkg::DRAW_ONE, 1'b1, 6'd0, 1'b1);
    add_row(16'hFFFF,  1'b1, 17'd0,      1'b1, 6'd0, 1'b0);
    add_row(16'hFFFF,  1'b1, 17'h1FFFF,  1'b1, 6'd0, 1'b0);
    // A zero draw with leading zero weights still lands on index zero.
    add_row(16'd0,     1'b0, 17'h1FFFF,  1'b0, 6'd0, 1'b0);
    add_row(16'd5,     1'b1, 17'd0,      1'b1, 6'd0, 1'b0);
    // Smallest nonzero draw skips the zero weights.
    add_row(16'd0,     1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'd0,     1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'd7,     1'b1, 17'd1,      1'b1, 6'd2, 1'b0);
    // Several weights that sum to zero.
    add_row(16'd0,     1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'd0,     1'b1, wis_pkg::DRAW_ONE, 1'b1, 6'd0, 1'b1);
    add_row(16'd1,     1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'hFFFF,  1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'd1,     1'b1, wis_pkg::DRAW_ONE, 1'b0, 6'd0, 1'b0);
    // Draw exactly on a prefix boundary, then just past it.
    add_row(16'd3,     1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'd1,     1'b1, 17'd49152,  1'b0, 6'd0, 1'b0);
    add_row(16'd3,     1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'd1,     1'b1, 17'd49153,  1'b0, 6'd0, 1'b0);
    add_row(16'hFFFF,  1'b0, 17'd0,      1'b0, 6'd0, 1'b0);
    add_row(16'hFFFF,  1'b1, 17'd65535,  1'b0, 6'd0, 1'b0);
    add_row(16'h5555,  1'b0, 17'h0AAAA,  1'b0, 6'd0, 1'b0);
    add_row(16'hAAAA,  1'b1, 17'h0AAAA,  1'b0, 6'd0, 1'b0);
    add_row(16'h1234,  1'b1, 17'h15555,  1'b1, 6'd0, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].w, dir_rows[i].last, dir_rows[i].d,
                dir_rows[i].typed, dir_rows[i].res);
      gap = pick_gap();
      if (i == dir_rows.size() - 1 && gap == 0) gap = 1;
      idle_after_beat(gap);
    end
    // Hold off until the directed draws are all back.
    wait_all_drawn();

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      style = $urandom_range(0, 99);
      if (style < 70) begin
        len = $urandom_range(1, 8);
      end else if (style < 90) begin
        len = $urandom_range(9, 40);
      end else if (style < 97) begin
        len = $urandom_range(60, WHEEL_DEPTH);
      end else begin
        len = $urandom_range(WHEEL_DEPTH + 1, WHEEL_DEPTH + 6);
      end
      if (len > WHEEL_DEPTH) overflow_sets++;
      if (len > longest_set) longest_set = len;
      style    = $urandom_range(0, 2);
      zero_set = ($urandom_range(0, 19) == 0);
      steady   = ($urandom_range(0, 9) == 0);
      pause    = ($urandom_range(0, 24) == 0);
      for (int k = 0; k < len; k++) begin
        w = zero_set ? wis_pkg::weight_t'(0) : pick_weight(style);
        d = (k == len - 1) ? pick_draw() : wis_pkg::draw_t'($urandom_range(0, 131071));
        send_beat(w, (k == len - 1), d, 1'b0, none);
        gap = steady ? 0 : pick_gap();
        if (k == len - 1 && (pause || beats_sent >= RANDOM_BEATS) && gap == 0) gap = 1;
        idle_after_beat(gap);
      end
      if (pause) wait_all_drawn();
    end

    wait_all_drawn();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_draws.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted draw results never arrived", $time, pending_draws.size());
    end
    $display("Checked %0d draw results (%0d with no_choice) after the directed table",
             draws_checked, no_choice_seen);
    $display("and %0d random beats; longest set %0d weights, %0d sets overran the store.",
             beats_sent, longest_set, overflow_sets);
    if (errors == 0) begin
      $display("tb_weighted_index_sampler: PASS");
    end else begin
      $display("tb_weighted_index_sampler: FAIL");
    end
    $finish;
  end

endmodule
